>>> rtl/core/tcpr_pkg.sv
package tcpr_pkg;

   // Field and state widths.
   localparam int CUR_W      = 24;
   localparam int GAIN_W     = 24;
   localparam int REF_W      = 12;
   localparam int ERR_W      = 25;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;

   // Full-precision step width: gain times error difference, plus the integral product.
   localparam int STEP_W = 51;

   // Register reset values that do not depend on the fraction width.
   localparam logic [GAIN_W-1:0] INT_GAIN_RESET  = GAIN_W'(66);
   localparam logic [REF_W-1:0]  START_REF_RESET = REF_W'(1000);

   // Register indexes of the configuration port.
   typedef enum logic [CSR_IDX_W-1:0] {
      REG_TARGET_CURRENT   = 3'd0,
      REG_PROP_GAIN        = 3'd1,
      REG_INT_GAIN         = 3'd2,
      REG_START_REFERENCE  = 3'd3,
      REG_CONTINUOUS_MODE  = 3'd4,
      REG_ALGORITHM_SELECT = 3'd5
   } csr_index_type;

   // Settings seen by the datapath.
   typedef struct packed {
      logic [CUR_W-1:0]  target_current;
      logic [GAIN_W-1:0] prop_gain;
      logic [GAIN_W-1:0] int_gain;
      logic              continuous_mode;
      logic              algorithm_select;
   } cfg_type;

   // Reload request raised by a write of the start reference.
   typedef struct packed {
      logic             load;
      logic [REF_W-1:0] value;
   } ref_load_type;

endpackage

>>> rtl/core/tcpr_csr.sv
module tcpr_csr
   import tcpr_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output cfg_type               cfg,
   output ref_load_type          ref_load
);

   // The proportional gain resets to 4.0 in the configured fixed-point format.
   localparam logic [GAIN_W-1:0] PROP_GAIN_RESET = GAIN_W'(64'd4 << FRAC_BITS);

   cfg_type cfg_ff;
   cfg_type cfg_in;
   logic [REF_W-1:0] start_ref_ff;
   logic [REF_W-1:0] start_ref_in;
   logic             load_in;

   // Register write decode.
   always_comb begin
      cfg_in       = cfg_ff;
      start_ref_in = start_ref_ff;
      load_in      = 1'b0;
      if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            REG_TARGET_CURRENT:   cfg_in.target_current = csr_wdata[CUR_W-1:0];
            REG_PROP_GAIN:        cfg_in.prop_gain = csr_wdata[GAIN_W-1:0];
            REG_INT_GAIN:         cfg_in.int_gain = csr_wdata[GAIN_W-1:0];
            REG_START_REFERENCE: begin
               start_ref_in = csr_wdata[REF_W-1:0];
               load_in      = 1'b1;
            end
            REG_CONTINUOUS_MODE:  cfg_in.continuous_mode = csr_wdata[0];
            REG_ALGORITHM_SELECT: cfg_in.algorithm_select = csr_wdata[0];
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.target_current   <= '0;
         cfg_ff.prop_gain        <= PROP_GAIN_RESET;
         cfg_ff.int_gain         <= INT_GAIN_RESET;
         cfg_ff.continuous_mode  <= 1'b0;
         cfg_ff.algorithm_select <= 1'b1;
         start_ref_ff            <= START_REF_RESET;
      end else begin
         cfg_ff       <= cfg_in;
         start_ref_ff <= start_ref_in;
      end
   end

   // The reload strobe is taken by the state registers in the same cycle as the write.
   assign cfg            = cfg_ff;
   assign ref_load.load  = load_in;
   assign ref_load.value = start_ref_in;

endmodule

>>> rtl/core/tcpr_datapath.sv
module tcpr_datapath
   import tcpr_pkg::*;
#(
   parameter int FRAC_BITS = 16,
   parameter int REF_LOW   = 1000,
   parameter int REF_HIGH  = 2450
) (
   input  cfg_type                  cfg,
   input  logic [CUR_W-1:0]         measured_current,
   input  logic                     limit_enable,
   input  logic [REF_W-1:0]         reference_value,
   input  logic signed [ERR_W-1:0]  previous_error,
   output logic [REF_W-1:0]         next_reference,
   output logic signed [ERR_W-1:0]  error_value
);

   // One and one half in the step format, which has twice the fraction bits.
   localparam logic signed [STEP_W-1:0] ONE      = STEP_W'(64'd1 << (2 * FRAC_BITS));
   localparam logic signed [STEP_W-1:0] HALF     = ONE >>> 1;
   localparam logic signed [STEP_W-1:0] NEG_ONE  = -ONE;
   localparam logic signed [STEP_W-1:0] NEG_HALF = -HALF;
   // |e| < 0.1 and |e| < 0.05 as exact compares against rounded-up bounds.
   localparam logic [ERR_W-1:0] DEADBAND =
      ERR_W'(((64'd1 << FRAC_BITS) + 64'd9) / 64'd10);
   localparam logic [ERR_W-1:0] NUDGE_BAND =
      ERR_W'(((64'd5 << FRAC_BITS) + 64'd99) / 64'd100);
   localparam logic signed [STEP_W-1:0] HIGH_W = STEP_W'(REF_HIGH);

   logic signed [ERR_W:0]      err_diff;
   logic signed [ERR_W:0]      prop_operand;
   logic signed [GAIN_W:0]     kp_s;
   logic signed [GAIN_W:0]     ki_s;
   logic signed [STEP_W-1:0]   prop_term;
   logic signed [STEP_W-1:0]   int_term;
   logic signed [STEP_W-1:0]   out_value;
   logic signed [STEP_W-1:0]   step;
   logic signed [STEP_W-1:0]   ref_sum;
   logic [ERR_W-1:0]           abs_err;
   logic [REF_W-1:0]           ref_clamped;

   // Error and its magnitude.
   assign error_value = $signed({1'b0, cfg.target_current}) - $signed({1'b0, measured_current});
   assign abs_err     = error_value[ERR_W-1] ? ERR_W'(-error_value) : ERR_W'(error_value);

   // Gain products; the integral term only exists in the incremental algorithm.
   assign err_diff     = {error_value[ERR_W-1], error_value} -
                         {previous_error[ERR_W-1], previous_error};
   assign prop_operand = cfg.algorithm_select ? err_diff
                                              : {error_value[ERR_W-1], error_value};
   assign kp_s         = $signed({1'b0, cfg.prop_gain});
   assign ki_s         = $signed({1'b0, cfg.int_gain});
   assign prop_term    = STEP_W'(kp_s * prop_operand);
   assign int_term     = cfg.algorithm_select ? STEP_W'(ki_s * error_value) : '0;
   assign out_value    = prop_term + int_term;

   // Step limit, then the algorithm-specific overrides.
   always_comb begin
      step = out_value;
      if (limit_enable && cfg.continuous_mode) begin
         if (step > ONE) begin
            step = ONE;
         end
         if (step < NEG_ONE) begin
            step = NEG_ONE;
         end
      end
      if (!cfg.algorithm_select) begin
         if (out_value > HALF && out_value < ONE) begin
            step = ONE;
         end
         if (out_value < NEG_HALF && out_value > NEG_ONE) begin
            step = NEG_ONE;
         end
      end else if (abs_err < DEADBAND) begin
         step = '0;
      end
   end

   // The reference is a whole number, so truncating the sum is the reference plus the
   // floor of the step; a negative sum gives a negative result here as well.
   assign ref_sum = $signed({{(STEP_W - REF_W){1'b0}}, reference_value}) +
                    (step >>> (2 * FRAC_BITS));

   always_comb begin
      ref_clamped = REF_W'(ref_sum);
      if (ref_sum < 0) begin
         ref_clamped = '0;
      end
      if (ref_sum > HIGH_W) begin
         ref_clamped = REF_W'(REF_HIGH);
      end
      // The lower bound is applied last, to the value already held at the upper bound.
      if (ref_clamped < REF_W'(REF_LOW)) begin
         ref_clamped = REF_W'(REF_LOW);
      end
      // The proportional algorithm nudges up near the target; 12-bit wrap is intended.
      next_reference = ref_clamped;
      if (!cfg.algorithm_select && abs_err < NUDGE_BAND) begin
         next_reference = ref_clamped + REF_W'(1);
      end
   end

endmodule

>>> rtl/core/tube_current_pi_regulator.sv
// Channel   Direction  Transaction                          Fields (lowest bit up)
// req_*     in         one measured current sample          tdata: measured_current[23:0]
//                                                           tuser: limit_enable
// rsp_*     out        one updated drive reference          tdata: drive_reference[11:0]
// csr_*     in         one register write, no wait          index 0..5, data up to 24 bits
//
// Each sample passes through an input register, then the regulator update into the result
// register. One sample is accepted every cycle while the result side is not stalled; the
// loop through the reference and error registers closes within the update cycle.
// Reset is synchronous and active high and restores the control, state and configuration registers to their defaults.
// A stalled result holds the input register, and the input side stalls only when both
// registers are full.
module tube_current_pi_regulator
   import tcpr_pkg::*;
#(
   parameter int FRAC_BITS = 16,
   parameter int REF_LOW   = 1000,
   parameter int REF_HIGH  = 2450
) (
   input  logic                  clock,
   input  logic                  reset,
   // Input samples.
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [23:0]           req_tdata,   // measured_current[23:0]
   input  logic                  req_tuser,   // limit_enable
   // Drive reference results.
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [15:0]           rsp_tdata,   // drive_reference[11:0], zero fill
   // Register writes.
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type      cfg;
   ref_load_type ref_load;

   logic                    in_valid_ff;
   logic [CUR_W-1:0]        in_meas_ff;
   logic                    in_limit_ff;
   logic                    out_valid_ff;
   logic [REF_W-1:0]        out_ref_ff;
   logic [REF_W-1:0]        ref_ff;
   logic [REF_W-1:0]        ref_in;
   logic signed [ERR_W-1:0] prev_err_ff;
   logic signed [ERR_W-1:0] prev_err_in;
   logic [REF_W-1:0]        next_reference;
   logic signed [ERR_W-1:0] error_value;
   logic                    out_free;
   logic                    advance;

   tcpr_csr #(
      .FRAC_BITS(FRAC_BITS)
   ) u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg),
      .ref_load  (ref_load)
   );

   tcpr_datapath #(
      .FRAC_BITS(FRAC_BITS),
      .REF_LOW  (REF_LOW),
      .REF_HIGH (REF_HIGH)
   ) u_datapath (
      .cfg              (cfg),
      .measured_current (in_meas_ff),
      .limit_enable     (in_limit_ff),
      .reference_value  (ref_ff),
      .previous_error   (prev_err_ff),
      .next_reference   (next_reference),
      .error_value      (error_value)
   );

   // Pipeline flow control.
   assign out_free   = !out_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;

   // Regulator state: a start reference write reloads it, an update moves it on.
   always_comb begin
      ref_in      = ref_ff;
      prev_err_in = prev_err_ff;
      if (ref_load.load) begin
         ref_in      = ref_load.value;
         prev_err_in = '0;
      end else if (advance) begin
         ref_in = next_reference;
         if (cfg.algorithm_select) begin
            prev_err_in = error_value;
         end
      end
   end

   // Control and state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         ref_ff       <= START_REF_RESET;
         prev_err_ff  <= '0;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (out_free) begin
            out_valid_ff <= in_valid_ff;
         end
         ref_ff      <= ref_in;
         prev_err_ff <= prev_err_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_meas_ff  <= req_tdata[CUR_W-1:0];
         in_limit_ff <= req_tuser;
      end
      if (advance) begin
         out_ref_ff <= next_reference;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(16 - REF_W){1'b0}}, out_ref_ff};

`ifndef SYNTHESIS
   // An update always leaves a result waiting in the output register.
   a_advance_gives_result: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_tvalid)
      else $error("update did not produce a result");

   // The result shown equals the reference state it was written with.
   a_result_matches_state: assert property (@(posedge clock) disable iff (reset)
      advance && !ref_load.load |=> out_ref_ff == ref_ff)
      else $error("result and reference state differ");

   // A start reference write loads the reference and clears the error history.
   a_load_restarts: assert property (@(posedge clock) disable iff (reset)
      ref_load.load |=> ref_ff == $past(ref_load.value) && prev_err_ff == '0)
      else $error("start reference reload failed");

   // The proportional algorithm never touches the error history.
   a_prop_keeps_history: assert property (@(posedge clock) disable iff (reset)
      advance && !cfg.algorithm_select && !ref_load.load |=> $stable(prev_err_ff))
      else $error("error history changed under the proportional algorithm");
`endif

endmodule

>>> verif/tube_current_pi_regulator_test.sv
module tube_current_pi_regulator_test;
   import tcpr_pkg::*;

   localparam int FRAC_BITS = 16;
   localparam int REF_LOW   = 1000;
   localparam int REF_HIGH  = 2450;

   localparam longint STEP_ONE  = longint'(1) << (2 * FRAC_BITS);
   localparam longint STEP_HALF = longint'(1) << (2 * FRAC_BITS - 1);
   localparam logic [CUR_W-1:0] CUR_MAX    = {CUR_W{1'b1}};
   localparam logic [CUR_W-1:0] MID_TARGET = CUR_W'(100 << FRAC_BITS);
   localparam int CYCLE_LIMIT = 200000;

   // Indexes outside the register map; writes to them must be ignored.
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_A = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_B = 3'd7;

   // Tracks the regulator state and holds the drive references still to come.
   class drive_ref_tracker;
      logic [CUR_W-1:0]        target_current;
      logic [GAIN_W-1:0]       prop_gain;
      logic [GAIN_W-1:0]       int_gain;
      logic                    continuous_mode;
      logic                    algorithm_select;
      logic [REF_W-1:0]        reference_value;
      logic signed [ERR_W-1:0] previous_error;
      logic [REF_W-1:0]        expected_refs[$];
      int                      mismatches;

      function new();
         target_current   = '0;
         prop_gain        = GAIN_W'(4 << FRAC_BITS);
         int_gain         = INT_GAIN_RESET;
         continuous_mode  = 1'b0;
         algorithm_select = 1'b1;
         reference_value  = START_REF_RESET;
         previous_error   = '0;
         mismatches       = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            REG_TARGET_CURRENT:   target_current = data[CUR_W-1:0];
            REG_PROP_GAIN:        prop_gain = data[GAIN_W-1:0];
            REG_INT_GAIN:         int_gain = data[GAIN_W-1:0];
            REG_START_REFERENCE: begin
               reference_value = data[REF_W-1:0];
               previous_error  = '0;
            end
            REG_CONTINUOUS_MODE:  continuous_mode = data[0];
            REG_ALGORITHM_SELECT: algorithm_select = data[0];
            default: ;
         endcase
      endfunction

      // One regulator update for an accepted sample, exact in 2*FRAC_BITS fraction bits.
      function void note_sample(logic [CUR_W-1:0] meas, logic limit_en);
         longint err, abs_err, step_raw, step, total, next_ref;
         err     = longint'(target_current) - longint'(meas);
         abs_err = (err < 0) ? -err : err;
         if (algorithm_select == 1'b0) begin
            step_raw = longint'(prop_gain) * err;
         end else begin
            step_raw = longint'(prop_gain) * (err - longint'(previous_error))
                       + longint'(int_gain) * err;
         end
         step = step_raw;
         if (limit_en && continuous_mode) begin
            if (step > STEP_ONE) step = STEP_ONE;
            if (step < -STEP_ONE) step = -STEP_ONE;
         end
         if (algorithm_select == 1'b0) begin
            if (step_raw > STEP_HALF && step_raw < STEP_ONE) step = STEP_ONE;
            if (step_raw < -STEP_HALF && step_raw > -STEP_ONE) step = -STEP_ONE;
         end else if (abs_err * 10 < (longint'(1) << FRAC_BITS)) begin
            step = 0;
         end
         total    = longint'(reference_value) * STEP_ONE + step;
         next_ref = (total < 0) ? 0 : total / STEP_ONE;
         if (next_ref > REF_HIGH) next_ref = REF_HIGH;
         if (next_ref < REF_LOW) next_ref = REF_LOW;
         if (algorithm_select == 1'b0) begin
            if (abs_err * 100 < (longint'(5) << FRAC_BITS)) next_ref = next_ref + 1;
         end else begin
            previous_error = ERR_W'(err);
         end
         reference_value = next_ref[REF_W-1:0];
         expected_refs.push_back(reference_value);
      endfunction

      function void check_reference(logic [15:0] tdata);
         logic [REF_W-1:0] want;
         if (expected_refs.size() == 0) begin
            $error("drive_reference: no result expected, actual %0d", tdata[REF_W-1:0]);
            mismatches++;
            return;
         end
         want = expected_refs.pop_front();
         if (tdata[REF_W-1:0] !== want) begin
            $error("drive_reference: expected %0d, actual %0d", want, tdata[REF_W-1:0]);
            mismatches++;
         end
         if (tdata[15:REF_W] !== '0) begin
            $error("rsp_tdata fill: expected 0, actual %0h", tdata[15:REF_W]);
            mismatches++;
         end
      endfunction
   endclass

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [23:0]           req_tdata  = '0;
   logic                  req_tuser  = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [15:0]           rsp_tdata;
   logic                  csr_wr_en  = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index  = '0;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;

   drive_ref_tracker tracker = new();
   int req_idle_pct  = 0;
   int rsp_stall_pct = 0;
   int cycle_count   = 0;

   tube_current_pi_regulator #(
      .FRAC_BITS(FRAC_BITS),
      .REF_LOW  (REF_LOW),
      .REF_HIGH (REF_HIGH)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Watchdog on the total run length.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // Result side: random back-pressure, and every accepted transaction is checked.
   initial begin
      forever begin
         @(negedge clock);
         rsp_tready = ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) tracker.check_reference(rsp_tdata);
   end

   // One register write; called at a falling edge while the block is idle.
   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_wr_en = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      @(posedge clock);
      tracker.write_reg(idx, data);
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   // Offers one sample, with a random idle gap first; tvalid stays high on return.
   task automatic send_sample(logic [CUR_W-1:0] meas, logic limit_en);
      while ($urandom_range(99) < req_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = meas;
      req_tuser  = limit_en;
      do begin
         @(posedge clock);
      end while (!req_tready);
      tracker.note_sample(meas, limit_en);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_tvalid = 1'b0;
      while (tracker.expected_refs.size() != 0) @(negedge clock);
   endtask

   // Mostly samples close to the target, so that steps stay small and the
   // thresholds are crossed; the rest are far off or fully random.
   function automatic logic [CUR_W-1:0] pick_current(logic [CUR_W-1:0] tgt);
      longint m;
      case ($urandom_range(9))
         0, 1: m = longint'($urandom() & CUR_MAX);
         2: m = $urandom_range(1) ? longint'(CUR_MAX) : 0;
         3: m = longint'(tgt) + $signed($urandom_range(2 << 20)) - (1 << 20);
         default: m = longint'(tgt) + $signed($urandom_range(16000)) - 8000;
      endcase
      if (m < 0) m = 0;
      if (m > longint'(CUR_MAX)) m = longint'(CUR_MAX);
      return m[CUR_W-1:0];
   endfunction

   // Settings for one random phase: all minimum, all maximum, then random mixes.
   task automatic apply_settings(int phase);
      logic [CUR_W-1:0]      tgt;
      logic [GAIN_W-1:0]     kp, ki;
      logic [REF_W-1:0]      sref;
      logic                  cont, alg;
      logic [CSR_DATA_W-1:0] junk;
      if (phase == 0) begin
         tgt = '0; kp = '0; ki = '0; sref = '0; cont = 1'b0; alg = 1'b0;
      end else if (phase == 1) begin
         tgt = CUR_MAX; kp = '1; ki = '1; sref = '1; cont = 1'b1; alg = 1'b1;
      end else begin
         case ($urandom_range(5))
            0: tgt = '0;
            1: tgt = CUR_MAX;
            default: tgt = CUR_W'($urandom());
         endcase
         case ($urandom_range(7))
            0: kp = '0;
            1: kp = '1;
            2: kp = GAIN_W'(4 << FRAC_BITS);
            3: kp = GAIN_W'(25 << FRAC_BITS);
            4: kp = GAIN_W'(1 << FRAC_BITS);
            default: kp = GAIN_W'($urandom_range(8 << FRAC_BITS));
         endcase
         case ($urandom_range(5))
            0: ki = '0;
            1: ki = '1;
            2: ki = INT_GAIN_RESET;
            3: ki = GAIN_W'(1 << FRAC_BITS);
            default: ki = GAIN_W'($urandom_range(2 << FRAC_BITS));
         endcase
         case ($urandom_range(5))
            0: sref = '0;
            1: sref = '1;
            2: sref = REF_W'(REF_LOW);
            3: sref = REF_W'(REF_HIGH);
            default: sref = REF_W'($urandom_range(REF_HIGH + 100, REF_LOW - 100));
         endcase
         cont = 1'($urandom_range(1));
         alg  = 1'($urandom_range(1));
      end
      write_csr(REG_TARGET_CURRENT, tgt);
      write_csr(REG_PROP_GAIN, kp);
      write_csr(REG_INT_GAIN, ki);
      // Sometimes the state carries over, so history survives gain and target writes.
      if (phase < 2 || $urandom_range(2) != 0) begin
         junk = CSR_DATA_W'($urandom());
         junk[REF_W-1:0] = sref;
         write_csr(REG_START_REFERENCE, junk);
      end
      junk = CSR_DATA_W'($urandom());
      junk[0] = cont;
      write_csr(REG_CONTINUOUS_MODE, junk);
      junk = CSR_DATA_W'($urandom());
      junk[0] = alg;
      write_csr(REG_ALGORITHM_SELECT, junk);
      if ($urandom_range(3) == 0) begin
         write_csr($urandom_range(1) ? REG_SPARE_A : REG_SPARE_B, CSR_DATA_W'($urandom()));
      end
   endtask

   initial begin
      repeat (4) @(negedge clock);
      reset = 1'b0;

      // Reset settings: incremental mode, extremes of the sample and the deadband edge.
      send_sample('0, 1'b0);
      send_sample(CUR_MAX, 1'b1);
      send_sample(CUR_W'(6553), 1'b0);
      send_sample(CUR_W'(6554), 1'b1);
      wait_drained();

      // Proportional mode: half-step rounding edges, nudge edges and the step clamp.
      write_csr(REG_TARGET_CURRENT, MID_TARGET);
      write_csr(REG_PROP_GAIN, GAIN_W'(1 << FRAC_BITS));
      write_csr(REG_INT_GAIN, '0);
      write_csr(REG_START_REFERENCE, CSR_DATA_W'(2000));
      write_csr(REG_CONTINUOUS_MODE, CSR_DATA_W'(1));
      write_csr(REG_ALGORITHM_SELECT, '0);
      send_sample(MID_TARGET - CUR_W'(32768), 1'b0);
      send_sample(MID_TARGET - CUR_W'(32769), 1'b0);
      send_sample(MID_TARGET + CUR_W'(32769), 1'b0);
      send_sample(MID_TARGET - CUR_W'(3276), 1'b0);
      send_sample(MID_TARGET - CUR_W'(3277), 1'b0);
      send_sample(MID_TARGET - CUR_W'(5 << FRAC_BITS), 1'b1);
      send_sample(MID_TARGET - CUR_W'(5 << FRAC_BITS), 1'b0);
      send_sample(MID_TARGET, 1'b1);
      wait_drained();

      // Incremental mode with large gains, top target and the deadband edge.
      write_csr(REG_TARGET_CURRENT, CUR_MAX);
      write_csr(REG_PROP_GAIN, GAIN_W'(25 << FRAC_BITS));
      write_csr(REG_INT_GAIN, GAIN_W'(1 << FRAC_BITS));
      write_csr(REG_START_REFERENCE, CSR_DATA_W'(REF_LOW));
      write_csr(REG_ALGORITHM_SELECT, CSR_DATA_W'(1));
      send_sample('0, 1'b0);
      send_sample(CUR_MAX, 1'b0);
      send_sample(CUR_MAX - CUR_W'(6553), 1'b1);
      send_sample(CUR_MAX - CUR_W'(6554), 1'b1);
      wait_drained();

      // Maximum gains, a start reference above the range, proportional history kept.
      write_csr(REG_TARGET_CURRENT, '0);
      write_csr(REG_PROP_GAIN, '1);
      write_csr(REG_INT_GAIN, '1);
      write_csr(REG_START_REFERENCE, CSR_DATA_W'(4095));
      write_csr(REG_CONTINUOUS_MODE, '0);
      write_csr(REG_ALGORITHM_SELECT, '0);
      send_sample('0, 1'b1);
      send_sample(CUR_MAX, 1'b0);
      wait_drained();
      write_csr(REG_SPARE_A, '1);
      write_csr(REG_SPARE_B, '0);
      write_csr(REG_ALGORITHM_SELECT, CSR_DATA_W'(1));
      send_sample('0, 1'b0);
      send_sample(CUR_W'(1 << FRAC_BITS), 1'b1);
      wait_drained();

      // Random phases, cycling through the idle and stall patterns.
      for (int phase = 0; phase < 14; phase++) begin
         case (phase % 4)
            0: begin req_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin req_idle_pct = 72; rsp_stall_pct = 0;  end
            2: begin req_idle_pct = 0;  rsp_stall_pct = 72; end
            default: begin req_idle_pct = 28; rsp_stall_pct = 28; end
         endcase
         apply_settings(phase);
         for (int n = 0; n < 38; n++) begin
            send_sample(pick_current(tracker.target_current), 1'($urandom_range(1)));
         end
         wait_drained();
      end

      repeat (8) @(negedge clock);
      if (tracker.mismatches == 0 && tracker.expected_refs.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

>>> files.f
rtl/core/tcpr_pkg.sv
rtl/core/tcpr_csr.sv
rtl/core/tcpr_datapath.sv
rtl/core/tube_current_pi_regulator.sv
verif/tube_current_pi_regulator_test.sv
